### src/mssc_pkg.sv
// Shared types, constants and checksum helper for the TCP SYN MSS clamp.
package mssc_pkg;

    // Fixed TCP header length in bytes and header field positions
    localparam int HDR_FIXED_LEN  = 20;
    localparam int POS_DATA_OFF   = 12;
    localparam int POS_FLAGS      = 13;
    localparam int POS_CSUM_HI    = 16;
    localparam int POS_CSUM_LO    = 17;
    localparam int POS_LAST_FIXED = 19;
    localparam int POS_MAX        = 63;

    // Option kinds and MSS option rules
    localparam logic [7:0] OPT_END     = 8'd0;
    localparam logic [7:0] OPT_NOP     = 8'd1;
    localparam logic [7:0] OPT_MSS     = 8'd2;
    localparam logic [7:0] MSS_OPT_LEN = 8'd4;
    localparam int         MSS_FLOOR   = 128;

    // Event queue depth between parser and clamp unit
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic REG_MSS_LIMIT = 1'b0;

    // Parser event: an MSS option value, the segment end, or both
    typedef struct packed {
        logic        has_mss;
        logic        is_end;
        logic        trunc;
        logic [15:0] old_mss;
        logic [5:0]  mss_offset;
        logic [15:0] checksum;
    } t_evt;

    // Result item, laid out so that it equals the output tdata word
    typedef struct packed {
        logic [15:0] new_checksum;
        logic [5:0]  mss_offset;
        logic [15:0] new_mss;
        logic [15:0] old_mss;
        logic        mss_changed;
        logic        mss_found;
    } t_res;

    // Incremental one's complement checksum update: ~(~hc + ~m + m')
    function automatic logic [15:0] csum_adjust(input logic [15:0] hc,
                                                input logic [15:0] m_old,
                                                input logic [15:0] m_new);
        logic [17:0] s0;
        logic [16:0] s1;
        logic [15:0] s2;
        s0 = {2'b00, ~hc} + {2'b00, ~m_old} + {2'b00, m_new};
        s1 = {1'b0, s0[15:0]} + {15'd0, s0[17:16]};
        s2 = s1[15:0] + {15'd0, s1[16]};
        return ~s2;
    endfunction

endpackage

### src/tcp_syn_mss_clamp_core.sv
// Timing: the segment-end event passes the event queue and output register; an
// MSS option ending on the last byte is applied first; backpressure adds delay.
// Throughput: one byte per cycle while the event queue is not full; the parser
// sets the rate; the queue absorbs clamp-unit steps and output stalls.
// Reset: synchronous active-low; clears parser, queue and clamp control state,
// and the mss_limit register reads 0.
module tcp_syn_mss_clamp_core #(
    parameter int Q_DEPTH = mssc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: tdata[7:0] = data_byte, tlast = last_byte
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    // Master stream: tdata[0] mss_found, [1] mss_changed, [17:2] old_mss,
    // [33:18] new_mss, [39:34] mss_offset, [55:40] new_checksum
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [16:0] r_mss_limit;
    logic               push;
    logic               full;
    logic               q_valid;
    logic               pop;
    mssc_pkg::t_evt     evt_in;
    mssc_pkg::t_evt     evt_out;
    mssc_pkg::t_res     res;

    // Configuration register write and read
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss_limit <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == mssc_pkg::REG_MSS_LIMIT) begin
            r_mss_limit <= $signed(pwdata[16:0]);
        end
    end
    assign prdata = (paddr[2] == mssc_pkg::REG_MSS_LIMIT) ?
                    {15'd0, r_mss_limit} : 32'd0;

    assign s_axis_tready = !full;

    mssc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_push  (push),
        .o_evt   (evt_in)
    );

    mssc_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (evt_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_evt   (evt_out)
    );

    mssc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_limit (r_mss_limit),
        .i_valid     (q_valid),
        .i_evt       (evt_out),
        .o_pop       (pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = res;

`ifndef SYNTHESIS
    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("event pushed into full queue");

    // A lowered MSS implies an option was found
    a_changed_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
        else $error("mss_changed without mss_found");

    // A lowered MSS lies above the floor and below the old value
    a_new_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |->
        (m_axis_tdata[33:18] > 16'd128) && (m_axis_tdata[33:18] < m_axis_tdata[17:2]))
        else $error("new MSS out of range");

    // Output is idle right after reset
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid after reset");
`endif

endmodule

### src/mssc_front.sv
// Byte parser: tracks header fields, walks TCP options and emits events.
module mssc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output logic               o_push,
    output mssc_pkg::t_evt     o_evt
);

    localparam logic [2:0] PH_FIXED  = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_MSS_HI = 3'd4;
    localparam logic [2:0] PH_MSS_LO = 3'd5;

    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_hdr, n_hdr;
    logic        r_syn, n_syn;
    logic [15:0] r_csum, n_csum;
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_mss_hi, n_mss_hi;
    logic        r_done, n_done;

    logic        accept;
    logic        walk;
    logic        mss_hit;
    logic [6:0]  pos_inc;
    logic [8:0]  opt_end;
    logic [7:0]  left_len;
    logic [7:0]  left_dec;

    assign accept   = i_valid && i_ready;
    assign pos_inc  = {1'b0, r_pos} + 7'd1;
    assign opt_end  = {3'b000, r_pos - 6'd1} + {1'b0, i_byte};
    assign left_len = i_byte - 8'd2;
    assign left_dec = r_left - 8'd1;
    assign walk     = (r_pos >= 6'(mssc_pkg::HDR_FIXED_LEN)) && !r_done && (r_pos < r_hdr);

    // Parse one byte: fixed header capture, then the option walk
    always_comb begin
        n_pos    = r_pos;
        n_hdr    = r_hdr;
        n_syn    = r_syn;
        n_csum   = r_csum;
        n_phase  = r_phase;
        n_code   = r_code;
        n_left   = r_left;
        n_mss_hi = r_mss_hi;
        n_done   = r_done;
        mss_hit  = 1'b0;

        if (r_pos == 6'd0) begin
            n_phase = PH_FIXED;
            n_done  = 1'b0;
        end

        if (r_pos < 6'(mssc_pkg::HDR_FIXED_LEN)) begin
            if (r_pos == 6'(mssc_pkg::POS_DATA_OFF)) begin
                n_hdr = {i_byte[7:4], 2'b00};
            end else if (r_pos == 6'(mssc_pkg::POS_FLAGS)) begin
                n_syn = i_byte[1];
            end else if (r_pos == 6'(mssc_pkg::POS_CSUM_HI)) begin
                n_csum = {i_byte, 8'd0};
            end else if (r_pos == 6'(mssc_pkg::POS_CSUM_LO)) begin
                n_csum = {r_csum[15:8], i_byte};
            end else if (r_pos == 6'(mssc_pkg::POS_LAST_FIXED)) begin
                n_phase = PH_TYPE;
                if (!r_syn) begin
                    n_done = 1'b1;
                end
            end
        end else if (walk) begin
            case (r_phase)
                PH_TYPE: begin
                    if (i_byte == mssc_pkg::OPT_END) begin
                        n_done = 1'b1;
                    end else if (i_byte != mssc_pkg::OPT_NOP) begin
                        if (pos_inc >= {1'b0, r_hdr}) begin
                            n_done = 1'b1;
                        end else begin
                            n_code  = i_byte;
                            n_phase = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    if (opt_end > {3'b000, r_hdr}) begin
                        n_done = 1'b1;
                    end else if (r_code == mssc_pkg::OPT_MSS &&
                                 i_byte == mssc_pkg::MSS_OPT_LEN) begin
                        n_phase = PH_MSS_HI;
                    end else if (i_byte < 8'd2) begin
                        n_done = 1'b1;
                    end else begin
                        n_left  = left_len;
                        n_phase = (left_len != 8'd0) ? PH_SKIP : PH_TYPE;
                    end
                end
                PH_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == 8'd0) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_MSS_HI: begin
                    n_mss_hi = i_byte;
                    n_phase  = PH_MSS_LO;
                end
                PH_MSS_LO: begin
                    // Clamp unit drops later options once it has lowered one
                    mss_hit = 1'b1;
                    n_phase = PH_TYPE;
                end
                default: begin
                    n_done = 1'b1;
                end
            endcase
        end

        // Advance the saturating position; restart at segment end
        if (i_last) begin
            n_pos = 6'd0;
        end else if (r_pos < 6'(mssc_pkg::POS_MAX)) begin
            n_pos = pos_inc[5:0];
        end
    end

    // Build the event for the queue
    always_comb begin
        o_evt.has_mss    = mss_hit;
        o_evt.is_end     = i_last;
        o_evt.trunc      = (pos_inc < 7'(mssc_pkg::HDR_FIXED_LEN)) ||
                           (pos_inc < {1'b0, r_hdr});
        o_evt.old_mss    = {r_mss_hi, i_byte};
        o_evt.mss_offset = r_pos - 6'd1;
        o_evt.checksum   = r_csum;
    end

    assign o_push = accept && (mss_hit || i_last);

    // Hold parser state between bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 6'd0;
            r_hdr   <= 6'd0;
            r_syn   <= 1'b0;
            r_phase <= PH_FIXED;
            r_done  <= 1'b0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_hdr   <= n_hdr;
            r_syn   <= n_syn;
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_csum   <= n_csum;
            r_code   <= n_code;
            r_left   <= n_left;
            r_mss_hi <= n_mss_hi;
        end
    end

endmodule

### src/mssc_queue.sv
// Small event queue between the parser and the clamp unit.
module mssc_queue #(
    parameter int DEPTH = mssc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mssc_pkg::t_evt  i_evt,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mssc_pkg::t_evt  o_evt
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mssc_pkg::t_evt r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_mem[r_rd];

    // Store entries at the write pointer
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### src/mssc_back.sv
// Clamp unit: applies the MSS limit per option and forms the result item.
module mssc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [16:0] i_cfg_limit,
    input  logic               i_valid,
    input  mssc_pkg::t_evt     i_evt,
    output logic               o_pop,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output mssc_pkg::t_res     o_res
);

    logic               r_fresh;
    logic               r_mss_done;
    logic               r_found;
    logic               r_changed;
    logic signed [17:0] r_run;
    logic [15:0]        r_old;
    logic [15:0]        r_new;
    logic [5:0]         r_off;
    logic [15:0]        r_hc;
    logic               r_ovalid;
    mssc_pkg::t_res     r_res;

    logic               do_mss;
    logic               do_end;
    logic               out_free;
    logic signed [17:0] lim_base;
    logic signed [17:0] lim_sum;
    logic signed [17:0] old_s;
    logic               lower;

    assign out_free = !r_ovalid || i_res_ready;
    assign do_mss   = i_valid && i_evt.has_mss && !r_mss_done;
    assign do_end   = i_valid && i_evt.is_end && !do_mss && out_free;
    assign o_pop    = (do_mss && !i_evt.is_end) || do_end;

    // Running limit: a negative limit absorbs the found MSS
    always_comb begin
        lim_base = r_fresh ? 18'(i_cfg_limit) : r_run;
        old_s    = $signed({2'b00, i_evt.old_mss});
        lim_sum  = (lim_base < 0) ? lim_base + old_s : lim_base;
        lower    = (lim_sum > $signed(18'(mssc_pkg::MSS_FLOOR))) && (old_s > lim_sum);
    end

    // Per-segment clamp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh    <= 1'b1;
            r_mss_done <= 1'b0;
            r_found    <= 1'b0;
            r_changed  <= 1'b0;
        end else if (do_end) begin
            r_fresh    <= 1'b1;
            r_mss_done <= 1'b0;
            r_found    <= 1'b0;
            r_changed  <= 1'b0;
        end else if (do_mss) begin
            r_mss_done <= i_evt.is_end;
            if (!r_changed) begin
                r_fresh <= 1'b0;
                r_found <= 1'b1;
                if (lower) begin
                    r_changed <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_mss && !r_changed) begin
            r_run <= lim_sum;
            r_old <= i_evt.old_mss;
            if (lower) begin
                r_new <= lim_sum[15:0];
                r_off <= i_evt.mss_offset;
                r_hc  <= i_evt.checksum;
            end
        end
    end

    // Output register: load at segment end, hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (do_end) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_end) begin
            if (i_evt.trunc) begin
                r_res <= '0;
            end else begin
                r_res.mss_found    <= r_found;
                r_res.mss_changed  <= r_changed;
                r_res.old_mss      <= r_found ? r_old : 16'd0;
                r_res.new_mss      <= r_changed ? r_new : 16'd0;
                r_res.mss_offset   <= r_changed ? r_off : 6'd0;
                r_res.new_checksum <= r_changed ?
                                      mssc_pkg::csum_adjust(r_hc, r_old, r_new) : 16'd0;
            end
        end
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;

endmodule
